// ===== rtl/rwhtp_pkg.sv =====
// ----------------------------------------------------------------------------
// rwhtp_pkg: shared types and constants
// Result codes, chunk identifiers and the queue entry type for the parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rwhtp_pkg;

    localparam logic [2:0] KIND_TEXT   = 3'd0;
    localparam logic [2:0] KIND_FORMAT = 3'd1;
    localparam logic [2:0] KIND_DONE   = 3'd2;
    localparam logic [2:0] KIND_ERROR  = 3'd3;
    localparam logic [2:0] KIND_EMPTY  = 3'd4;

    localparam logic [2:0] TAG_UNKNOWN = 3'd7;

    localparam logic [31:0] ID_RIFF = 32'h4646_4952;
    localparam logic [31:0] ID_WAVE = 32'h4556_4157;
    localparam logic [31:0] ID_FMT  = 32'h2074_6d66;
    localparam logic [31:0] ID_LIST = 32'h5453_494c;
    localparam logic [31:0] ID_INFO = 32'h4f46_4e49;

    localparam int TAG_COUNT = 7;
    localparam logic [31:0] TAG_IDS [TAG_COUNT] = '{
        32'h5452_4149, 32'h4452_4349, 32'h524e_4749, 32'h4d41_4e49,
        32'h4452_5049, 32'h4b52_5449, 32'h544d_4349
    };

    localparam logic [9:0] MS_PER_S = 10'd1000;
    localparam int QUEUE_DEPTH = 4;
    localparam int DIV_STEPS   = 42;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  tag_type;
        logic [31:0] chunk_id;
        logic [7:0]  text_byte;
        logic        text_last;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       r0;
        res_t       r1;
    } push_t;

    typedef struct packed {
        logic [2:0] level;
        logic       valid;
    } queue_status_t;

    typedef struct packed {
        logic busy;
    } back_status_t;

endpackage

`default_nettype wire

// ===== rtl/rwhtp_front.sv =====
// ----------------------------------------------------------------------------
// rwhtp_front: byte parser
// Walks the RIFF header and chunks, pushes up to two results per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rwhtp_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 take,
    input  wire logic [7:0]           data_byte,
    input  wire logic                 end_of_stream,
    input  wire logic [12:0]          text_limit,
    output rwhtp_pkg::push_t          push
);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_FORMAT = 3'd1;
    localparam logic [2:0] PH_TEXT   = 3'd2;
    localparam logic [2:0] PH_SKIP   = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;
    localparam logic [2:0] PH_ERROR  = 3'd5;

    logic [2:0]  phase_reg, phase_next;
    logic [63:0] hb_reg, hb_next;
    logic [3:0]  pos_reg, pos_next;
    logic [31:0] outer_reg, outer_next;
    logic [31:0] crem_reg, crem_next;
    logic [1:0]  cnum_reg, cnum_next;
    logic        info_reg, info_next;
    logic [2:0]  tag_reg, tag_next;
    logic        bad_reg, bad_next;
    logic [47:0] fmt_reg, fmt_next;

    always_comb
    begin
        logic        v0;
        logic        fin;
        logic        fin_err;
        logic        ce;
        logic [31:0] id;
        logic [31:0] size;
        logic [31:0] o;
        logic [31:0] lim;
        logic [3:0]  p;
        rwhtp_pkg::res_t prim;
        rwhtp_pkg::res_t fres;

        phase_next = phase_reg;
        hb_next    = hb_reg;
        pos_next   = pos_reg;
        outer_next = outer_reg;
        crem_next  = crem_reg;
        cnum_next  = cnum_reg;
        info_next  = info_reg;
        tag_next   = tag_reg;
        bad_next   = bad_reg;
        fmt_next   = fmt_reg;
        v0 = 1'b0;
        fin = 1'b0;
        fin_err = 1'b0;
        ce = 1'b0;
        prim = '0;
        fres = '0;
        id = '0;
        size = '0;
        o = '0;
        p = pos_reg;
        lim = {19'd0, text_limit} - 32'd5;

        if (phase_reg == PH_DONE || phase_reg == PH_ERROR)
        begin
            v0 = 1'b0;
        end
        else if (end_of_stream)
        begin
            fin = 1'b1;
            fin_err = 1'b1;
        end
        else
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    hb_next  = {data_byte, hb_reg[63:8]};
                    pos_next = pos_reg + 4'd1;
                    id   = hb_next[31:0];
                    size = hb_next[63:32];
                    if (cnum_reg == 2'd0)
                    begin
                        if (pos_next == 4'd4 && size != rwhtp_pkg::ID_RIFF)
                            bad_next = 1'b1;
                        if (pos_next == 4'd12)
                        begin
                            if (bad_reg || size != rwhtp_pkg::ID_WAVE || id < 32'd4)
                            begin
                                fin = 1'b1;
                                fin_err = 1'b1;
                            end
                            else
                            begin
                                bad_next   = 1'b0;
                                outer_next = id - 32'd4;
                                cnum_next  = 2'd1;
                                crem_next  = '0;
                                ce = 1'b1;
                            end
                        end
                    end
                    else if (pos_next == 4'd8)
                    begin
                        if (cnum_reg < 2'd2)
                            cnum_next = cnum_reg + 2'd1;
                        if (id == rwhtp_pkg::ID_INFO)
                        begin
                            info_next = 1'b1;
                            pos_next  = 4'd4;
                        end
                        else if (outer_reg <= 32'd8)
                        begin
                            fin = 1'b1;
                        end
                        else
                        begin
                            o = outer_reg - 32'd8;
                            if (o < size)
                                fin = 1'b1;
                            else
                            begin
                                outer_next = o - size;
                                if (cnum_reg == 2'd1)
                                begin
                                    if (id != rwhtp_pkg::ID_FMT || size < 32'd16)
                                    begin
                                        fin = 1'b1;
                                        fin_err = 1'b1;
                                    end
                                    else
                                    begin
                                        crem_next  = size - 32'd16;
                                        fmt_next   = '0;
                                        hb_next    = '0;
                                        pos_next   = '0;
                                        phase_next = PH_FORMAT;
                                    end
                                end
                                else if (id == rwhtp_pkg::ID_LIST)
                                begin
                                    if (size < 32'd4)
                                    begin
                                        fin = 1'b1;
                                        fin_err = 1'b1;
                                    end
                                    else
                                    begin
                                        outer_next = size - 32'd4;
                                        crem_next  = '0;
                                        ce = 1'b1;
                                    end
                                end
                                else if (info_reg && text_limit > 13'd5 && size < lim)
                                begin
                                    tag_next = rwhtp_pkg::TAG_UNKNOWN;
                                    for (int k = rwhtp_pkg::TAG_COUNT - 1; k >= 0; k--)
                                        if (rwhtp_pkg::TAG_IDS[k] == id)
                                            tag_next = 3'(k);
                                    crem_next = size;
                                    if (size == 32'd0)
                                    begin
                                        v0 = 1'b1;
                                        prim.kind = rwhtp_pkg::KIND_EMPTY;
                                        prim.tag_type = tag_next;
                                        prim.chunk_id =
                                            (tag_next == rwhtp_pkg::TAG_UNKNOWN) ? id : '0;
                                        ce = 1'b1;
                                    end
                                    else
                                        phase_next = PH_TEXT;
                                end
                                else
                                begin
                                    crem_next = size;
                                    ce = 1'b1;
                                end
                            end
                        end
                    end
                end
                PH_FORMAT:
                begin
                    if (p >= 4'd2 && p <= 4'd7)
                        fmt_next[8*(p-4'd2) +: 8] = data_byte;
                    else if (p >= 4'd8 && p <= 4'd11)
                        hb_next[8*(p-4'd8) +: 8] = hb_reg[8*(p-4'd8) +: 8] | data_byte;
                    pos_next = p + 4'd1;
                    if (p == 4'd15)
                    begin
                        if (fmt_next[15:0] == '0 || fmt_next[47:16] == '0
                            || hb_next[31:0] == '0)
                        begin
                            fin = 1'b1;
                            fin_err = 1'b1;
                        end
                        else
                        begin
                            v0 = 1'b1;
                            prim.kind = rwhtp_pkg::KIND_FORMAT;
                            prim.channel_count = fmt_next[15:0];
                            prim.sample_rate = fmt_next[47:16];
                            prim.dividend = outer_reg;
                            prim.divisor = hb_next[31:0];
                            ce = 1'b1;
                        end
                    end
                end
                PH_TEXT:
                begin
                    crem_next = crem_reg - 32'd1;
                    v0 = 1'b1;
                    prim.kind = rwhtp_pkg::KIND_TEXT;
                    prim.tag_type = tag_reg;
                    prim.chunk_id = (tag_reg == rwhtp_pkg::TAG_UNKNOWN) ? hb_reg[31:0] : '0;
                    prim.text_byte = data_byte;
                    prim.text_last = (crem_next == '0);
                    if (crem_next == '0)
                        ce = 1'b1;
                end
                default:
                begin
                    crem_next = crem_reg - 32'd1;
                    if (crem_next == '0)
                    begin
                        phase_next = PH_HEADER;
                        pos_next = '0;
                    end
                end
            endcase
        end

        // end of a chunk: finish, next header or skip
        if (ce)
        begin
            if (outer_next == '0)
                fin = 1'b1;
            else if (crem_next == '0)
            begin
                phase_next = PH_HEADER;
                pos_next = '0;
            end
            else
                phase_next = PH_SKIP;
        end

        if (fin)
        begin
            phase_next = fin_err ? PH_ERROR : PH_DONE;
            fres.kind = fin_err ? rwhtp_pkg::KIND_ERROR : rwhtp_pkg::KIND_DONE;
        end

        push.count = take ? (2'(v0) + 2'(fin)) : 2'd0;
        push.r0 = v0 ? prim : fres;
        push.r1 = fres;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            hb_reg    <= '0;
            pos_reg   <= '0;
            outer_reg <= 32'd1;
            crem_reg  <= '0;
            cnum_reg  <= '0;
            info_reg  <= 1'b0;
            tag_reg   <= '0;
            bad_reg   <= 1'b0;
            fmt_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            hb_reg    <= hb_next;
            pos_reg   <= pos_next;
            outer_reg <= outer_next;
            crem_reg  <= crem_next;
            cnum_reg  <= cnum_next;
            info_reg  <= info_next;
            tag_reg   <= tag_next;
            bad_reg   <= bad_next;
            fmt_reg   <= fmt_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rwhtp_queue.sv =====
// ----------------------------------------------------------------------------
// rwhtp_queue: result queue
// Takes up to two results per cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module rwhtp_queue (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire rwhtp_pkg::push_t        push,
    input  wire logic                    pop,
    output rwhtp_pkg::res_t              head,
    output rwhtp_pkg::queue_status_t     status
);

    localparam int PW = $clog2(rwhtp_pkg::QUEUE_DEPTH);

    rwhtp_pkg::res_t mem [rwhtp_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   level_reg;
    logic [PW-1:0] wp1;

    assign wp1 = wp_reg + PW'(1);
    assign head = mem[rp_reg];
    assign status.level = 3'(level_reg);
    assign status.valid = (level_reg != '0);

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wp_reg] <= push.r0;
        if (push.count == 2'd2)
            mem[wp1] <= push.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            level_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_reg + PW'(push.count);
            rp_reg    <= rp_reg + PW'(pop);
            level_reg <= level_reg + (PW+1)'(push.count) - (PW+1)'(pop);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rwhtp_back.sv =====
// ----------------------------------------------------------------------------
// rwhtp_back: result output stage
// Drains the queue, works out the duration by restoring division.
// ----------------------------------------------------------------------------
`default_nettype none

module rwhtp_back (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire rwhtp_pkg::res_t         head,
    input  wire logic                    head_valid,
    output logic                         pop,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output rwhtp_pkg::res_t              res,
    output logic [31:0]                  duration_ms,
    output rwhtp_pkg::back_status_t      status
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam int QW = rwhtp_pkg::DIV_STEPS;

    logic [1:0]    state_reg;
    logic          valid_reg;
    logic [5:0]    step_reg;
    logic [31:0]   rem_reg;
    logic [QW-1:0] quo_reg;
    logic [31:0]   dur_reg;
    rwhtp_pkg::res_t res_reg;

    logic [32:0]   trial;
    logic          ge;
    logic          free;

    assign free  = !valid_reg || out_ready;
    assign pop   = head_valid && (state_reg == ST_IDLE) && free;
    assign trial = {rem_reg, quo_reg[QW-1]};
    assign ge    = trial >= {1'b0, res_reg.divisor};

    assign out_valid   = valid_reg;
    assign res         = res_reg;
    assign duration_ms = dur_reg;
    assign status.busy = (state_reg != ST_IDLE);

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    res_reg <= head;
                    dur_reg <= '0;
                end
            end
            ST_MUL:
            begin
                rem_reg <= '0;
                quo_reg <= QW'(res_reg.dividend) * QW'(rwhtp_pkg::MS_PER_S);
            end
            ST_DIV:
            begin
                rem_reg <= ge ? 32'(trial - {1'b0, res_reg.divisor}) : trial[31:0];
                quo_reg <= {quo_reg[QW-2:0], ge};
                if (step_reg == 6'(QW - 1))
                    dur_reg <= (quo_reg[QW-2:31] != '0) ? '1 : {quo_reg[30:0], ge};
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        if (head.kind == rwhtp_pkg::KIND_FORMAT)
                        begin
                            state_reg <= ST_MUL;
                            valid_reg <= 1'b0;
                        end
                        else
                            valid_reg <= 1'b1;
                    end
                    else if (out_ready)
                        valid_reg <= 1'b0;
                end
                ST_MUL:
                begin
                    step_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'(QW - 1))
                    begin
                        state_reg <= ST_IDLE;
                        valid_reg <= 1'b1;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/riff_wave_header_tag_parser_unit.sv =====
// ----------------------------------------------------------------------------
// riff_wave_header_tag_parser_unit: RIFF/WAVE header and INFO tag parser
// Byte stream in, format, tag text and status results out.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready with data_byte and end_of_stream, one
// byte of the file per transfer. Output channel: out_valid/out_ready with
// kind, tag_type, chunk_id, text_byte, text_last, channel_count,
// sample_rate and duration_ms; one transfer per result.
// The front parser takes one byte per cycle while the result queue (four
// entries) has room for two results; a byte may give up to two results.
// A result passes through the result queue to the output register.
// The format result waits for the duration divider: a multiply step
// and 42 restoring steps between its pop and the output register;
// bytes keep flowing meanwhile until the queue fills. Output rate is at
// most one result per cycle, set by the single output register.
// A stalled receiver holds the output register, the queue fills and then
// in_ready drops. After done or error bytes are still taken and dropped.
// Reset empties the queue and returns the parser to the RIFF header;
// text_limit returns to 256. text_limit is written over the APB port.
// ----------------------------------------------------------------------------
`default_nettype none

module riff_wave_header_tag_parser_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_stream,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       kind,
    output logic [2:0]       tag_type,
    output logic [31:0]      chunk_id,
    output logic [7:0]       text_byte,
    output logic             text_last,
    output logic [15:0]      channel_count,
    output logic [31:0]      sample_rate,
    output logic [31:0]      duration_ms,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [12:0] text_limit_reg;
    logic        take;
    logic        pop;

    rwhtp_pkg::push_t          push;
    rwhtp_pkg::res_t           head;
    rwhtp_pkg::res_t           res;
    rwhtp_pkg::queue_status_t  q_status;
    rwhtp_pkg::back_status_t   b_status;

    // config register: only register 0 exists, upper word ignored
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {19'd0, text_limit_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            text_limit_reg <= 13'd256;
        else if (psel && penable && pwrite && paddr[2] == 1'b0)
            text_limit_reg <= pwdata[12:0];
    end

    // room for the worst case of two results per byte
    assign in_ready = (q_status.level <= 3'(rwhtp_pkg::QUEUE_DEPTH - 2));
    assign take     = in_valid && in_ready;

    rwhtp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .text_limit    (text_limit_reg),
        .push          (push)
    );

    rwhtp_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .head   (head),
        .status (q_status)
    );

    rwhtp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .head_valid  (q_status.valid),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .res         (res),
        .duration_ms (duration_ms),
        .status      (b_status)
    );

    assign kind          = res.kind;
    assign tag_type      = res.tag_type;
    assign chunk_id      = res.chunk_id;
    assign text_byte     = res.text_byte;
    assign text_last     = res.text_last;
    assign channel_count = res.channel_count;
    assign sample_rate   = res.sample_rate;

`ifndef SYNTH
    // queue never overfills
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.level <= 3'(rwhtp_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    // no result is presented while the divider runs
    a_busy_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        b_status.busy |-> !out_valid)
        else $error("output valid during division");

    // a pop only happens when the queue holds an entry
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_status.valid)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire
